// ----- src/cnv3_pkg.sv -----
// Shared types and constants for the 3x3 convolution block.
// No dependencies; every other file refers to this package by scoped name.
package cnv3_pkg;

    localparam int PIX_W      = 8;
    localparam int KROW_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_FIELD_W = 12;
    localparam int PIX_MAX    = 255;

    // Laplacian edge kernel, left coefficient in the low byte
    localparam logic [KROW_W-1:0] KROW_OUTER_RST  = 24'hFFFFFF;
    localparam logic [KROW_W-1:0] KROW_MIDDLE_RST = 24'hFF08FF;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [KROW_W-1:0] krow_t;
    typedef pix_t [8:0]        window_t;

    // border flags for one result, plus end-of-image mark
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } tag_t;

endpackage

// ----- src/cnv3_if.sv -----
// Valid/ready channel interfaces for pixel requests and convolution results.
// Depends on cnv3_pkg for the pixel type.
interface cnv3_in_if;
    logic          valid;
    logic          ready;
    logic          action;
    cnv3_pkg::pix_t pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface cnv3_out_if;
    logic          valid;
    logic          ready;
    cnv3_pkg::pix_t pixel_out;
    logic          last;

    modport source (output valid, output pixel_out, output last, input ready);
    modport sink   (input valid, input pixel_out, input last, output ready);
endinterface

// ----- src/conv3x3_zero_pad_clamp.sv -----
// Streaming 3x3 convolution with zero padding and 0..255 clamp. Accepts one
// request per clock: each pixel or flush does one read of each line store and
// one write, so the store ports set the rate, and nothing in the path stalls
// unless the result channel holds back. The request that completes a window is
// one row and one pixel past its center pixel; its result goes through the store
// read, window, product and result registers to the result channel.
// After the last pixel, send image_width+1 flush requests to drain. The line
// stores need no clearing after reset, since border masking hides every entry
// not yet written.
// Depends on cnv3_pkg, cnv3_if, cnv3_ctrl, cnv3_line_buf and cnv3_mac.
module conv3x3_zero_pad_clamp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int COEFF_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cnv3_in_if.sink                         pixels,
    cnv3_out_if.source                      results,
    input  logic                            cfg_we,
    input  logic [cnv3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cnv3_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic              s1_ready, load, load_emit, s2_valid, s3_ready;
    cnv3_pkg::pix_t    load_pix;
    logic [AW-1:0]     load_col;
    cnv3_pkg::tag_t    load_tag, s2_tag;
    cnv3_pkg::window_t window;
    cnv3_pkg::krow_t   kernel_top, kernel_mid, kernel_bot;

    cnv3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixels     (pixels),
        .s1_ready   (s1_ready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .load       (load),
        .load_pix   (load_pix),
        .load_col   (load_col),
        .load_emit  (load_emit),
        .load_tag   (load_tag),
        .kernel_top (kernel_top),
        .kernel_mid (kernel_mid),
        .kernel_bot (kernel_bot)
    );

    cnv3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_pix  (load_pix),
        .load_col  (load_col),
        .load_emit (load_emit),
        .load_tag  (load_tag),
        .s1_ready  (s1_ready),
        .s2_valid  (s2_valid),
        .window    (window),
        .s2_tag    (s2_tag),
        .s3_ready  (s3_ready)
    );

    cnv3_mac #(
        .COEFF_BITS (COEFF_BITS)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2_valid   (s2_valid),
        .window     (window),
        .s2_tag     (s2_tag),
        .s3_ready   (s3_ready),
        .kernel_top (kernel_top),
        .kernel_mid (kernel_mid),
        .kernel_bot (kernel_bot),
        .results    (results)
    );

endmodule

// ----- src/cnv3_ctrl.sv -----
// Configuration registers and raster position tracking for the 3x3 convolution.
// Decides per request whether it shifts in and whether it yields a result. Uses cnv3_pkg.
module cnv3_ctrl #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1),
    localparam int HW = $clog2(MAX_HEIGHT + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 2),
    localparam int DW = $clog2(MAX_WIDTH + 3)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    cnv3_in_if.sink                             pixels,
    input  logic                                s1_ready,
    input  logic                                cfg_we,
    input  logic [cnv3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cnv3_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                load,
    output cnv3_pkg::pix_t                      load_pix,
    output logic [AW-1:0]                       load_col,
    output logic                                load_emit,
    output cnv3_pkg::tag_t                      load_tag,
    output cnv3_pkg::krow_t                     kernel_top,
    output cnv3_pkg::krow_t                     kernel_mid,
    output cnv3_pkg::krow_t                     kernel_bot
);

    localparam int W_RST = (2048 > MAX_WIDTH) ? MAX_WIDTH : 2048;
    localparam int H_RST = (2048 > MAX_HEIGHT) ? MAX_HEIGHT : 2048;

    logic [WW-1:0] width_reg,  width_next;
    logic [HW-1:0] height_reg, height_next;
    cnv3_pkg::krow_t ktop_reg, kmid_reg, kbot_reg;

    logic [AW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [DW-1:0] pend_reg,    pend_next;    // inputs taken minus results given
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [HW-1:0] out_row_reg, out_row_next;

    logic          accept, complete, do_shift, wrap, emit, restart;
    logic [WW:0]   col_inc;
    logic [DW-1:0] pend_inc;
    logic [31:0]   size_val;
    cnv3_pkg::cfg_reg_t cfg_sel;
    cnv3_pkg::tag_t tag;

    assign pixels.ready = s1_ready;
    assign accept   = pixels.valid && s1_ready;
    assign cfg_sel  = cnv3_pkg::cfg_reg_t'(cfg_index);
    assign size_val = {{(32 - cnv3_pkg::SIZE_FIELD_W){1'b0}},
                       cfg_data[cnv3_pkg::SIZE_FIELD_W-1:0]};
    assign restart  = cfg_we && (cfg_sel == cnv3_pkg::REG_IMAGE_WIDTH ||
                                 cfg_sel == cnv3_pkg::REG_IMAGE_HEIGHT);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_sel)
                cnv3_pkg::REG_IMAGE_WIDTH:
                    width_next = WW'((size_val == 32'd0) ? 32'd1 :
                                     (size_val > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : size_val);
                cnv3_pkg::REG_IMAGE_HEIGHT:
                    height_next = HW'((size_val == 32'd0) ? 32'd1 :
                                      (size_val > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : size_val);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        complete = in_row_reg >= RW'(height_reg);
        do_shift = (pixels.action == cnv3_pkg::ACT_FLUSH) ? complete : !complete;
        col_inc  = (WW+1)'(in_col_reg) + (WW+1)'(1);
        wrap     = col_inc >= (WW+1)'(width_reg);
        pend_inc = pend_reg + DW'(1);
        // a result is due once the window holds the row below it
        emit     = {1'b0, pend_inc} >= ((DW+1)'(width_reg) + (DW+1)'(2));

        tag.top_ok   = out_row_reg != '0;
        tag.bot_ok   = ((HW+1)'(out_row_reg) + (HW+1)'(1)) < (HW+1)'(height_reg);
        tag.left_ok  = out_col_reg != '0;
        tag.right_ok = ((WW+1)'(out_col_reg) + (WW+1)'(1)) < (WW+1)'(width_reg);
        tag.last     = !tag.bot_ok && !tag.right_ok;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        pend_next    = pend_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            pend_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (load)
        begin
            in_col_next = wrap ? '0 : AW'(col_inc);
            in_row_next = wrap ? in_row_reg + RW'(1) : in_row_reg;
            pend_next   = emit ? pend_reg : pend_inc;
            if (emit)
            begin
                if (tag.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    pend_next    = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (!tag.right_ok)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    assign load      = accept && do_shift;
    assign load_pix  = (pixels.action == cnv3_pkg::ACT_FLUSH) ? '0 : pixels.pixel_in;
    assign load_col  = in_col_reg;
    assign load_emit = emit;
    assign load_tag  = tag;

    assign kernel_top = ktop_reg;
    assign kernel_mid = kmid_reg;
    assign kernel_bot = kbot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WW'(W_RST);
            height_reg  <= HW'(H_RST);
            ktop_reg    <= cnv3_pkg::KROW_OUTER_RST;
            kmid_reg    <= cnv3_pkg::KROW_MIDDLE_RST;
            kbot_reg    <= cnv3_pkg::KROW_OUTER_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            pend_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            pend_reg    <= pend_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (cfg_we && cfg_sel == cnv3_pkg::REG_KERNEL_TOP)
                ktop_reg <= cfg_data[cnv3_pkg::KROW_W-1:0];
            if (cfg_we && cfg_sel == cnv3_pkg::REG_KERNEL_MIDDLE)
                kmid_reg <= cfg_data[cnv3_pkg::KROW_W-1:0];
            if (cfg_we && cfg_sel == cnv3_pkg::REG_KERNEL_BOTTOM)
                kbot_reg <= cfg_data[cnv3_pkg::KROW_W-1:0];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (WW+1)'(in_col_reg) < (WW+1)'(width_reg))
    else $error("input column beyond image width");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_row_reg < height_reg)
    else $error("output row beyond image height");

    assert property (@(posedge clk) disable iff (!rst_n)
        (DW+1)'(pend_reg) <= ((DW+1)'(width_reg) + (DW+1)'(1)))
    else $error("pending result count overran the line delay");

endmodule

// ----- src/cnv3_line_buf.sv -----
// Two line stores and the 3x3 window register. Stage 1 holds the store read,
// stage 2 is the window with its border tag. Uses cnv3_pkg.
module cnv3_line_buf #(
    parameter int MAX_WIDTH = 2048,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cnv3_pkg::pix_t    load_pix,
    input  logic [AW-1:0]     load_col,
    input  logic              load_emit,
    input  cnv3_pkg::tag_t    load_tag,
    output logic              s1_ready,
    output logic              s2_valid,
    output cnv3_pkg::window_t window,
    output cnv3_pkg::tag_t    s2_tag,
    input  logic              s3_ready
);

    cnv3_pkg::pix_t mem_upper [MAX_WIDTH];
    cnv3_pkg::pix_t mem_lower [MAX_WIDTH];

    logic              s1_valid_reg;
    cnv3_pkg::pix_t    s1_pix_reg;
    logic [AW-1:0]     s1_col_reg;
    logic              s1_emit_reg;
    cnv3_pkg::tag_t    s1_tag_reg;
    cnv3_pkg::pix_t    rd_top_reg, rd_mid_reg;
    logic              fwd_reg;
    cnv3_pkg::pix_t    fwd_top_reg, fwd_mid_reg;

    logic              s2_valid_reg;
    cnv3_pkg::tag_t    s2_tag_reg;
    cnv3_pkg::window_t window_reg;

    logic              s1_adv, s2_ready;
    cnv3_pkg::pix_t    top_s1, mid_s1;

    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s1_adv;

    // one-pixel-wide images reread the column written on the same edge
    assign top_s1 = fwd_reg ? fwd_top_reg : rd_top_reg;
    assign mid_s1 = fwd_reg ? fwd_mid_reg : rd_mid_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_top_reg <= mem_upper[load_col];
            rd_mid_reg <= mem_lower[load_col];
        end
        if (s1_adv)
        begin
            mem_upper[s1_col_reg] <= mid_s1;
            mem_lower[s1_col_reg] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_pix_reg  <= load_pix;
            s1_col_reg  <= load_col;
            s1_emit_reg <= load_emit;
            s1_tag_reg  <= load_tag;
            fwd_top_reg <= mid_s1;
            fwd_mid_reg <= s1_pix_reg;
        end
        if (s1_adv)
            s2_tag_reg <= s1_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            if (load)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (load)
                fwd_reg <= s1_adv && (load_col == s1_col_reg);

            if (s1_adv)
                s2_valid_reg <= s1_emit_reg;
            else if (s3_ready)
                s2_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    window_reg[r*3]     <= window_reg[r*3 + 1];
                    window_reg[r*3 + 1] <= window_reg[r*3 + 2];
                end
                window_reg[2] <= top_s1;
                window_reg[5] <= mid_s1;
                window_reg[8] <= s1_pix_reg;
            end
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_tag   = s2_tag_reg;
    assign window   = window_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> $stable(window_reg))
    else $error("window moved under a held result");

endmodule

// ----- src/cnv3_mac.sv -----
// Coefficient multiply stage, then sum, clamp and the result register.
// Uses cnv3_pkg; drives the result channel.
module cnv3_mac #(
    parameter int COEFF_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s2_valid,
    input  cnv3_pkg::window_t window,
    input  cnv3_pkg::tag_t    s2_tag,
    output logic              s3_ready,
    input  cnv3_pkg::krow_t   kernel_top,
    input  cnv3_pkg::krow_t   kernel_mid,
    input  cnv3_pkg::krow_t   kernel_bot,
    cnv3_out_if.source        results
);

    localparam int PW = COEFF_BITS + cnv3_pkg::PIX_W + 1;
    localparam int SW = PW + 4;

    logic                 s3_valid_reg;
    logic signed [PW-1:0] prod_reg [9];
    logic signed [PW-1:0] prod_next [9];
    logic                 s3_last_reg;
    logic                 out_valid_reg;
    cnv3_pkg::pix_t       out_pix_reg;
    logic                 out_last_reg;

    logic                 out_free, s3_adv, take;
    logic [2:0]           row_ok, col_ok;
    cnv3_pkg::krow_t      krow;
    logic signed [COEFF_BITS-1:0] coef;
    logic signed [SW-1:0] sum;
    cnv3_pkg::pix_t       clamped;

    assign out_free = !out_valid_reg || results.ready;
    assign s3_ready = !s3_valid_reg || out_free;
    assign s3_adv   = s3_valid_reg && out_free;
    assign take     = s2_valid && s3_ready;

    assign row_ok = {s2_tag.bot_ok, 1'b1, s2_tag.top_ok};
    assign col_ok = {s2_tag.right_ok, 1'b1, s2_tag.left_ok};

    always_comb
    begin
        krow = kernel_top;
        coef = '0;
        for (int k = 0; k < 9; k++)
        begin
            unique case (k / 3)
                0:       krow = kernel_top;
                1:       krow = kernel_mid;
                default: krow = kernel_bot;
            endcase
            coef = $signed(krow[8*(k % 3) +: COEFF_BITS]);
            if (row_ok[k / 3] && col_ok[k % 3])
                prod_next[k] = PW'(coef) * $signed({1'b0, window[k]});
            else
                prod_next[k] = '0;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 9; k++)
            sum = sum + SW'(prod_reg[k]);
        if (sum < 0)
            clamped = '0;
        else if (sum > SW'(cnv3_pkg::PIX_MAX))
            clamped = cnv3_pkg::pix_t'(cnv3_pkg::PIX_MAX);
        else
            clamped = sum[cnv3_pkg::PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_reg    <= prod_next;
            s3_last_reg <= s2_tag.last;
        end
        if (s3_adv)
        begin
            out_pix_reg  <= clamped;
            out_last_reg <= s3_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                s3_valid_reg <= 1'b1;
            else if (s3_adv)
                s3_valid_reg <= 1'b0;

            if (s3_adv)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.pixel_out = out_pix_reg;
    assign results.last      = out_last_reg;

endmodule

// ----- dv/conv3x3_zero_pad_clamp_test.sv -----
// Self-checking bench for conv3x3_zero_pad_clamp: directed frame, then random frames.
// Needs cnv3_pkg, cnv3_if and the block's RTL; the line-store predictor lives here.
`timescale 1ns / 1ps

module conv3x3_zero_pad_clamp_test;

    localparam int MAX_LINE      = 2048;
    localparam int MAX_ROWS      = 2048;
    localparam int RANDOM_ITEMS  = 950;
    localparam int DRAIN_CYCLES  = 8;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int REPORT_LIMIT  = 10;
    localparam int IDX_W         = cnv3_pkg::CFG_IDX_W;
    localparam int DATA_W        = cnv3_pkg::CFG_DATA_W;
    localparam int SIZE_W        = cnv3_pkg::SIZE_FIELD_W;
    localparam int SMALL_AREA    = 64;
    localparam int REG_UNMAPPED_LO = int'(cnv3_pkg::REG_KERNEL_BOTTOM) + 1;
    localparam int REG_INDEX_TOP   = (1 << IDX_W) - 1;

    typedef enum int { SHAPE_SMALL, SHAPE_WIDE, SHAPE_TALL } frame_shape_t;

    typedef struct packed {
        cnv3_pkg::pix_t value;
        logic last;
    } conv_result_t;

    typedef struct packed {
        logic act;
        cnv3_pkg::pix_t pix;
        logic pinned;
        cnv3_pkg::pix_t want;
        logic want_last;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0] cfg_data;

    cnv3_in_if  pixel_req ();
    cnv3_out_if conv_res ();

    conv3x3_zero_pad_clamp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixel_req),
        .results   (conv_res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    int unsigned     img_w, img_h;
    cnv3_pkg::krow_t kernel_rows [3];
    cnv3_pkg::pix_t  upper_line [MAX_LINE];
    cnv3_pkg::pix_t  lower_line [MAX_LINE];
    cnv3_pkg::pix_t  win [9];
    int unsigned     img_col, img_row, out_pos;

    conv_result_t pending_pixels [$];
    int           mismatch_count;
    int unsigned  requests_sent;
    int unsigned  burst_left, gap_max, stall_pct, stall_run;
    bit           sink_open;
    bit           pin_on;
    conv_result_t pin_res;

    // 3x3 frame, all 255 but a black top-left pixel: only the corner result is 0
    stim_row_t directed_rows [0:19] = '{
        '{cnv3_pkg::ACT_FLUSH, 8'hFF, 1'b0, 8'd0,   1'b0},  // flush ahead of a full frame
        '{cnv3_pkg::ACT_PIXEL, 8'h00, 1'b0, 8'd0,   1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b0, 8'd0,   1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b0, 8'd0,   1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b0, 8'd0,   1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b1, 8'd0,   1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b1, 8'd255, 1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b1, 8'd255, 1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b1, 8'd255, 1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFF, 1'b1, 8'd255, 1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'h5A, 1'b0, 8'd0,   1'b0},  // pixel past frame end
        '{cnv3_pkg::ACT_FLUSH, 8'h00, 1'b1, 8'd255, 1'b0},
        '{cnv3_pkg::ACT_FLUSH, 8'h00, 1'b1, 8'd255, 1'b0},
        '{cnv3_pkg::ACT_FLUSH, 8'h00, 1'b1, 8'd255, 1'b0},
        '{cnv3_pkg::ACT_FLUSH, 8'h00, 1'b1, 8'd255, 1'b1},
        '{cnv3_pkg::ACT_FLUSH, 8'h00, 1'b0, 8'd0,   1'b0},  // flush past the drain
        '{cnv3_pkg::ACT_PIXEL, 8'h01, 1'b0, 8'd0,   1'b0},  // partial frame, cut by a size write
        '{cnv3_pkg::ACT_PIXEL, 8'h80, 1'b0, 8'd0,   1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'h7F, 1'b0, 8'd0,   1'b0},
        '{cnv3_pkg::ACT_PIXEL, 8'hFE, 1'b0, 8'd0,   1'b0}
    };

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void restart_counters();
        img_col = 0;
        img_row = 0;
        out_pos = 0;
    endfunction

    function automatic void reset_model();
        img_w = MAX_LINE;
        img_h = MAX_ROWS;
        kernel_rows[0] = cnv3_pkg::KROW_OUTER_RST;
        kernel_rows[1] = cnv3_pkg::KROW_MIDDLE_RST;
        kernel_rows[2] = cnv3_pkg::KROW_OUTER_RST;
        for (int i = 0; i < MAX_LINE; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        restart_counters();
    endfunction

    function automatic void load_register(input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] data);
        case (idx)
            cnv3_pkg::REG_IMAGE_WIDTH:
            begin
                img_w = clamp_size(32'(data[SIZE_W-1:0]), MAX_LINE);
                restart_counters();
            end
            cnv3_pkg::REG_IMAGE_HEIGHT:
            begin
                img_h = clamp_size(32'(data[SIZE_W-1:0]), MAX_ROWS);
                restart_counters();
            end
            cnv3_pkg::REG_KERNEL_TOP:    kernel_rows[0] = data;
            cnv3_pkg::REG_KERNEL_MIDDLE: kernel_rows[1] = data;
            cnv3_pkg::REG_KERNEL_BOTTOM: kernel_rows[2] = data;
            default: ;
        endcase
    endfunction

    function automatic void shift_pixel(input cnv3_pkg::pix_t v);
        int unsigned c;
        cnv3_pkg::pix_t above, here;
        c = img_col % MAX_LINE;
        above = upper_line[c];
        here  = lower_line[c];
        upper_line[c] = here;
        lower_line[c] = v;
        for (int r = 0; r < 3; r++)
        begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = above;
        win[5] = here;
        win[8] = v;
        img_col++;
        if (img_col >= img_w)
        begin
            img_col = 0;
            img_row++;
        end
    endfunction

    function automatic cnv3_pkg::pix_t convolve_at(input int unsigned q);
        int unsigned crow, ccol;
        int acc, coef;
        bit row_ok, col_ok;
        crow = q / img_w;
        ccol = q % img_w;
        acc  = 0;
        for (int r = 0; r < 3; r++)
        begin
            row_ok = (r == 0) ? (crow > 0) : (r == 2) ? (crow + 1 < img_h) : 1'b1;
            for (int j = 0; j < 3; j++)
            begin
                col_ok = (j == 0) ? (ccol > 0) : (j == 2) ? (ccol + 1 < img_w) : 1'b1;
                if (row_ok && col_ok)
                begin
                    // coefficient width equals the byte, so the byte is the signed value
                    coef = $signed(kernel_rows[r][8*j +: 8]);
                    acc += coef * int'(win[r*3 + j]);
                end
            end
        end
        if (acc > cnv3_pkg::PIX_MAX)
            acc = cnv3_pkg::PIX_MAX;
        if (acc < 0)
            acc = 0;
        return cnv3_pkg::pix_t'(acc);
    endfunction

    // one accepted request; returns 1 when it releases a result
    function automatic bit advance_image(input logic act, input cnv3_pkg::pix_t pix,
                                         output conv_result_t res);
        int unsigned filled;
        res = '0;
        if (act == cnv3_pkg::ACT_FLUSH)
        begin
            if (img_row < img_h)
                return 0;
            shift_pixel('0);
        end
        else
        begin
            if (img_row >= img_h)
                return 0;
            shift_pixel(pix);
        end
        filled = img_row * img_w + img_col;
        if (out_pos >= img_w * img_h || filled - out_pos < img_w + 2)
            return 0;
        res.value = convolve_at(out_pos);
        out_pos++;
        if (out_pos >= img_w * img_h)
        begin
            res.last = 1'b1;
            restart_counters();
        end
        return 1;
    endfunction

    function automatic cnv3_pkg::pix_t rand_pixel();
        case ($urandom_range(7, 0))
            0: return 8'h00;
            1: return 8'hFF;
            default: return cnv3_pkg::pix_t'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic int unsigned pick_size();
        case ($urandom_range(9, 0))
            0: return 0;
            1: return 1;
            default: return $urandom_range(7, 2);
        endcase
    endfunction

    // size in the low field, junk above it
    function automatic logic [DATA_W-1:0] size_word(input int unsigned sz);
        logic [DATA_W-1:0] w;
        w = DATA_W'($urandom);
        w[SIZE_W-1:0] = SIZE_W'(sz);
        return w;
    endfunction

    function automatic cnv3_pkg::krow_t pick_kernel_row(input cnv3_pkg::krow_t laplace);
        case ($urandom_range(5, 0))
            0: return laplace;
            1: return 24'h808080;
            2: return 24'h7F7F7F;
            default: return cnv3_pkg::krow_t'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        load_register(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic act, input cnv3_pkg::pix_t pix, input bit pinned,
                                input conv_result_t fixed);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(32, 1);
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            if (gap > 0)
            begin
                @(negedge clk);
                pixel_req.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        pixel_req.valid    <= 1'b1;
        pixel_req.action   <= act;
        pixel_req.pixel_in <= pix;
        pin_on  = pinned;
        pin_res = fixed;
        @(posedge clk);
        while (pixel_req.ready !== 1'b1) @(posedge clk);
        requests_sent++;
    endtask

    // block drained and quiet: safe to touch registers
    task automatic wait_idle();
        @(negedge clk);
        pixel_req.valid <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input frame_shape_t shape);
        int unsigned need, count, style;
        wait_idle();
        gap_max   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
        stall_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 10);
        case (shape)
            SHAPE_WIDE:
            begin
                write_reg(cnv3_pkg::REG_IMAGE_WIDTH, size_word(12'hFFF));
                write_reg(cnv3_pkg::REG_IMAGE_HEIGHT, size_word(1));
            end
            SHAPE_TALL:
            begin
                write_reg(cnv3_pkg::REG_IMAGE_WIDTH, size_word(0));
                write_reg(cnv3_pkg::REG_IMAGE_HEIGHT, size_word(12'hFFF));
            end
            default:
                if ($urandom_range(3, 0) != 0 || img_w * img_h > SMALL_AREA)
                begin
                    write_reg(cnv3_pkg::REG_IMAGE_WIDTH, size_word(pick_size()));
                    write_reg(cnv3_pkg::REG_IMAGE_HEIGHT, size_word(pick_size()));
                end
        endcase
        if (shape != SHAPE_SMALL || $urandom_range(1, 0))
            write_reg(cnv3_pkg::REG_KERNEL_TOP, pick_kernel_row(cnv3_pkg::KROW_OUTER_RST));
        if (shape != SHAPE_SMALL || $urandom_range(1, 0))
            write_reg(cnv3_pkg::REG_KERNEL_MIDDLE, pick_kernel_row(cnv3_pkg::KROW_MIDDLE_RST));
        if (shape != SHAPE_SMALL || $urandom_range(1, 0))
            write_reg(cnv3_pkg::REG_KERNEL_BOTTOM, pick_kernel_row(cnv3_pkg::KROW_OUTER_RST));
        if ($urandom_range(9, 0) == 0)
            write_reg(IDX_W'($urandom_range(REG_INDEX_TOP, REG_UNMAPPED_LO)),
                      DATA_W'($urandom));

        need  = (img_row < img_h) ? img_w * img_h - (img_row * img_w + img_col) : 0;
        // the extreme shapes only get a short mixed run at the top of the frame
        style = (shape == SHAPE_SMALL) ? $urandom_range(19, 0) : 19;
        if (style < 14)
        begin
            // whole frame plus drain, a stray flush now and then
            for (int unsigned i = 0; i < need; i++)
            begin
                if ($urandom_range(39, 0) == 0)
                    send_request(cnv3_pkg::ACT_FLUSH, rand_pixel(), 1'b0, '0);
                send_request(cnv3_pkg::ACT_PIXEL, rand_pixel(), 1'b0, '0);
            end
            if ($urandom_range(5, 0) == 0)
                send_request(cnv3_pkg::ACT_PIXEL, rand_pixel(), 1'b0, '0);
            count = img_w + 1 + $urandom_range(2, 0);
            for (int unsigned i = 0; i < count; i++)
                send_request(cnv3_pkg::ACT_FLUSH, rand_pixel(), 1'b0, '0);
        end
        else if (style < 17)
        begin
            // frame cut short
            count = need * $urandom_range(99, 0) / 100;
            for (int unsigned i = 0; i < count; i++)
                send_request(cnv3_pkg::ACT_PIXEL, rand_pixel(), 1'b0, '0);
            count = $urandom_range(3, 0);
            for (int unsigned i = 0; i < count; i++)
                send_request(cnv3_pkg::ACT_FLUSH, rand_pixel(), 1'b0, '0);
        end
        else
        begin
            count = $urandom_range(30, 5);
            for (int unsigned i = 0; i < count; i++)
                send_request(1'($urandom_range(1, 0)), rand_pixel(), 1'b0, '0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // result side: ready held open or closed for runs of random length
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run = $urandom_range(8, 1);
            sink_open = ($urandom_range(100, 1) > stall_pct);
        end
        stall_run--;
        conv_res.ready <= sink_open;
    end

    always @(posedge clk)
    begin : check_results
        conv_result_t got, want;
        bit produced;
        if (rst_n)
        begin
            if (conv_res.valid === 1'b1 && conv_res.ready)
            begin
                got.value = conv_res.pixel_out;
                got.last  = conv_res.last;
                if (pending_pixels.size() == 0)
                    flag_error($sformatf("unexpected result pixel %0d last %0b",
                                         got.value, got.last));
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.value !== want.value)
                        flag_error($sformatf("pixel_out expected %0d got %0d",
                                             want.value, got.value));
                    if (got.last !== want.last)
                        flag_error($sformatf("last expected %0b got %0b",
                                             want.last, got.last));
                end
            end
            if (pixel_req.valid && pixel_req.ready === 1'b1)
            begin
                produced = advance_image(pixel_req.action, pixel_req.pixel_in, got);
                if (pin_on)
                    pending_pixels.push_back(pin_res);
                else if (produced)
                    pending_pixels.push_back(got);
            end
        end
    end

    initial
    begin : stimulus
        int unsigned base;
        conv_result_t fixed;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pixel_req.valid    = 1'b0;
        pixel_req.action   = cnv3_pkg::ACT_PIXEL;
        pixel_req.pixel_in = '0;
        mismatch_count     = 0;
        requests_sent      = 0;
        burst_left         = 0;
        stall_run          = 0;
        gap_max            = 2;
        stall_pct          = 20;
        pin_on             = 1'b0;
        pin_res            = '0;
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(cnv3_pkg::REG_IMAGE_WIDTH, size_word(3));
        write_reg(cnv3_pkg::REG_IMAGE_HEIGHT, size_word(3));
        write_reg(IDX_W'(REG_UNMAPPED_LO), '0);  // must leave the 3x3 setup alone
        foreach (directed_rows[i])
        begin
            fixed.value = directed_rows[i].want;
            fixed.last  = directed_rows[i].want_last;
            send_request(directed_rows[i].act, directed_rows[i].pix,
                         directed_rows[i].pinned, fixed);
        end
        wait_idle();
        write_reg(cnv3_pkg::REG_IMAGE_HEIGHT, size_word(2));  // restart mid-frame

        base = requests_sent;
        run_phase(SHAPE_WIDE);
        run_phase(SHAPE_TALL);
        while (requests_sent - base < RANDOM_ITEMS)
            run_phase(SHAPE_SMALL);

        @(negedge clk);
        pixel_req.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (2 * DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
